### hw/rtl/xed_pkg.sv
// Package with the shared types, codes and entity tables of the XML entity decoder.
package xed_pkg;

    localparam int CHAR_W   = 21;
    localparam int OUT_W    = 32;
    localparam int STATUS_W = 3;
    localparam int ADDR_W   = 3;
    localparam int APB_W    = 32;
    localparam int ENT_N    = 5;
    localparam int POS_W    = 3;

    // Register index of ignore_entities (address bit 2 selects the register).
    localparam logic REG_IGNORE_IDX = 1'b0;

    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t ST_OK      = 3'd0;
    localparam status_t ST_UNKNOWN = 3'd1;
    localparam status_t ST_INVALID = 3'd2;
    localparam status_t ST_OPEN    = 3'd3;
    localparam status_t ST_ATTR    = 3'd4;

    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_NAME = 6'b000010,
        PH_HASH = 6'b000100,
        PH_DEC  = 6'b001000,
        PH_HEX  = 6'b010000,
        PH_SKIP = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [OUT_W-1:0] char_out;
        status_t          status;
        logic             out_last;
    } result_t;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_X     = 8'h78;

    // Entity names after the ampersand, padded to eight places.
    typedef logic [7:0] name_row_t [8];
    localparam name_row_t ENT_TEXT [ENT_N] = '{
        '{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // lt;
        '{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // gt;
        '{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00},  // quot;
        '{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00},  // amp;
        '{8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B, 8'h00, 8'h00, 8'h00}   // apos;
    };
    localparam logic [POS_W-1:0] ENT_LEN  [ENT_N] = '{3'd3, 3'd3, 3'd5, 3'd4, 3'd5};
    localparam logic [7:0]       ENT_CHAR [ENT_N] = '{8'h3C, 8'h3E, 8'h22, 8'h26, 8'h27};

endpackage

### hw/rtl/xml_entity_decoder_top.sv
// Top level of the streaming XML character entity decoder.
//
//  Port group   Dir  Handshake          Content
//  s_*          in   s_tvalid/s_tready  one code point, attribute flag, segment end
//  m_*          out  m_tvalid/m_tready  decoded character, status, last result
//  APB          in   psel/penable       ignore_entities register at address 0
//
// The block takes one item in every cycle while s_tready is high. The entity state
// is updated in the same cycle in which an item is accepted. Its result, if any, is
// registered in the output register, or in the skid register when the output
// register is full, so the block can take an item while the output is stalled;
// s_tready falls only when both hold a result. Reset is synchronous and active low;
// it empties both registers, returns the decoder to idle and clears the register.
module xml_entity_decoder_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input items.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // [20:0] char_in, [23:21] zero
    input  logic                           s_tuser,   // [0] in_attribute
    input  logic                           s_tlast,   // seg_last
    // Result items.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [xed_pkg::OUT_W-1:0]      m_tdata,   // [31:0] char_out
    output logic [xed_pkg::STATUS_W-1:0]   m_tuser,   // [2:0] status
    output logic                           m_tlast,   // out_last
    // Configuration.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [xed_pkg::ADDR_W-1:0]     paddr,
    input  logic [xed_pkg::APB_W-1:0]      pwdata,
    output logic [xed_pkg::APB_W-1:0]      prdata,
    output logic                           pready
);
    import xed_pkg::*;

    logic                  ignore_reg;
    phase_t                phase_reg, phase_next;
    logic [POS_W-1:0]      name_pos_reg, name_pos_next;
    logic [ENT_N-1:0]      name_cand_reg, name_cand_next;
    logic [OUT_W-1:0]      code_reg, code_next;
    logic                  have_digit_reg, have_digit_next;

    logic                  out_valid_reg, skid_valid_reg;
    result_t               out_data_reg, skid_data_reg;

    logic [CHAR_W-1:0]     c;
    logic                  attr, seg_last, accept_in, push, pop;
    logic                  res_valid;
    result_t               res;
    logic                  fail_req;
    status_t               fail_status;
    logic [ENT_N-1:0]      keep;
    logic                  done_found;
    logic [7:0]            done_char;
    logic                  is_dec;
    logic [4:0]            hex_d;
    logic [OUT_W-1:0]      dec_acc;

    // Hex digit value with a valid flag in the top bit.
    function automatic logic [4:0] hex_digit(input logic [CHAR_W-1:0] ch);
        logic [4:0] r;
        r = 5'd0;
        if (ch >= CHAR_W'(8'h30) && ch <= CHAR_W'(8'h39)) begin
            r = {1'b1, ch[3:0]};
        end else if ((ch >= CHAR_W'(8'h61) && ch <= CHAR_W'(8'h66)) ||
                     (ch >= CHAR_W'(8'h41) && ch <= CHAR_W'(8'h46))) begin
            r = {1'b1, ch[3:0] + 4'd9};
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access cycle.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IGNORE_IDX) ? APB_W'(ignore_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ignore_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_IGNORE_IDX) begin
            ignore_reg <= pwdata[0];
        end
    end

    // ------------------------------------------------------------------
    // Decoder: one state update per accepted item.
    // ------------------------------------------------------------------
    assign c         = s_tdata[CHAR_W-1:0];
    assign attr      = s_tuser;
    assign seg_last  = s_tlast;
    assign s_tready  = !skid_valid_reg;
    assign accept_in = s_tvalid && s_tready;

    assign is_dec  = (c >= CHAR_W'(8'h30)) && (c <= CHAR_W'(8'h39));
    assign hex_d   = hex_digit(c);
    // Times ten plus the digit, as two shifted terms.
    assign dec_acc = {code_reg[28:0], 3'b000} + {code_reg[30:0], 1'b0} + OUT_W'(c[3:0]);

    always_comb begin
        keep       = '0;
        done_found = 1'b0;
        done_char  = 8'h00;
        for (int k = 0; k < ENT_N; k++) begin
            if (name_cand_reg[k] && name_pos_reg < ENT_LEN[k] &&
                c == CHAR_W'(ENT_TEXT[k][name_pos_reg])) begin
                keep[k] = 1'b1;
            end
        end
        for (int k = ENT_N - 1; k >= 0; k--) begin
            if (keep[k] && (name_pos_reg + POS_W'(1)) == ENT_LEN[k]) begin
                done_found = 1'b1;
                done_char  = ENT_CHAR[k];
            end
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        name_pos_next   = name_pos_reg;
        name_cand_next  = name_cand_reg;
        code_next       = code_reg;
        have_digit_next = have_digit_reg;
        res_valid       = 1'b0;
        res             = '{char_out: '0, status: ST_OK, out_last: seg_last};
        fail_req        = 1'b0;
        fail_status     = ST_OK;

        case (phase_reg)
            PH_SKIP: begin
                if (seg_last) begin
                    phase_next = PH_IDLE;
                end
            end
            PH_NAME: begin
                if (name_pos_reg == '0 && c == CHAR_W'(CH_HASH)) begin
                    phase_next      = PH_HASH;
                    code_next       = '0;
                    have_digit_next = 1'b0;
                    fail_req        = seg_last;
                    fail_status     = ST_UNKNOWN;
                end else if (keep == '0) begin
                    fail_req    = 1'b1;
                    fail_status = ST_UNKNOWN;
                end else if (done_found) begin
                    phase_next   = PH_IDLE;
                    res_valid    = 1'b1;
                    res.char_out = OUT_W'(done_char);
                end else begin
                    name_cand_next = keep;
                    name_pos_next  = name_pos_reg + POS_W'(1);
                    fail_req       = seg_last;
                    fail_status    = ST_UNKNOWN;
                end
            end
            PH_HASH: begin
                if (c == CHAR_W'(CH_X)) begin
                    phase_next  = PH_HEX;
                    fail_req    = seg_last;
                    fail_status = ST_OPEN;
                end else if (is_dec) begin
                    phase_next      = PH_DEC;
                    code_next       = OUT_W'(c[3:0]);
                    have_digit_next = 1'b1;
                    fail_req        = seg_last;
                    fail_status     = ST_OPEN;
                end else begin
                    fail_req    = 1'b1;
                    fail_status = ST_INVALID;
                end
            end
            PH_DEC, PH_HEX: begin
                if ((phase_reg == PH_DEC) ? is_dec : hex_d[4]) begin
                    code_next       = (phase_reg == PH_DEC) ? dec_acc
                                                            : {code_reg[27:0], hex_d[3:0]};
                    have_digit_next = 1'b1;
                    fail_req        = seg_last;
                    fail_status     = ST_OPEN;
                end else if (c == CHAR_W'(CH_SEMI) && have_digit_reg) begin
                    phase_next   = PH_IDLE;
                    res_valid    = 1'b1;
                    res.char_out = code_reg;
                end else begin
                    fail_req    = 1'b1;
                    fail_status = ST_INVALID;
                end
            end
            default: begin
                // Idle: a fresh entity context on every character.
                phase_next = PH_IDLE;
                if (c == CHAR_W'(CH_AMP) && !ignore_reg) begin
                    phase_next  = PH_NAME;
                    fail_req    = seg_last;
                    fail_status = ST_UNKNOWN;
                end else if (attr && c == CHAR_W'(CH_LT)) begin
                    fail_req    = 1'b1;
                    fail_status = ST_ATTR;
                end else begin
                    res_valid    = 1'b1;
                    res.char_out = OUT_W'(c);
                    if (attr && (c == CHAR_W'(CH_NL) || c == CHAR_W'(CH_TAB))) begin
                        res.char_out = OUT_W'(CH_SPACE);
                    end
                end
            end
        endcase

        // Any return to idle starts the next entity from scratch.
        if (phase_next == PH_IDLE || fail_req) begin
            name_pos_next   = '0;
            name_cand_next  = '1;
            code_next       = '0;
            have_digit_next = 1'b0;
        end
        // An error ends the segment's output and swallows the rest of it.
        if (fail_req) begin
            phase_next = seg_last ? PH_IDLE : PH_SKIP;
            res_valid  = 1'b1;
            res        = '{char_out: '0, status: fail_status, out_last: 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            name_pos_reg   <= '0;
            name_cand_reg  <= '1;
            code_reg       <= '0;
            have_digit_reg <= 1'b0;
        end else if (accept_in) begin
            phase_reg      <= phase_next;
            name_pos_reg   <= name_pos_next;
            name_cand_reg  <= name_cand_next;
            code_reg       <= code_next;
            have_digit_reg <= have_digit_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register with a skid register behind it.
    // ------------------------------------------------------------------
    assign push = accept_in && res_valid;
    assign pop  = out_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            if (out_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res;
        end else if (push) begin
            if (out_valid_reg) begin
                skid_data_reg <= res;
            end else begin
                out_data_reg <= res;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg.char_out;
    assign m_tuser  = out_data_reg.status;
    assign m_tlast  = out_data_reg.out_last;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds an item while the output register is empty");

    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tlast && m_tdata == '0))
        else $error("error result without last mark or with nonzero character");

    a_skip_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept_in && phase_reg == PH_SKIP && seg_last) |=> phase_reg == PH_IDLE)
        else $error("swallowing did not end at the segment end");

    a_skip_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept_in && phase_reg == PH_SKIP) |-> !push)
        else $error("result produced while swallowing");

    a_name_cand: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_NAME) |-> (name_cand_reg != '0))
        else $error("entity name phase with no candidate left");

endmodule
